[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AST_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bole_pkg.sv]
package bole_pkg;

    typedef enum logic [3:0] {
        REQ_READ      = 4'd0,
        REQ_ASSIGN    = 4'd1,
        REQ_INSERT    = 4'd2,
        REQ_PUSH_TAIL = 4'd3,
        REQ_PUSH_HEAD = 4'd4,
        REQ_REMOVE    = 4'd5,
        REQ_POP_TAIL  = 4'd6,
        REQ_POP_HEAD  = 4'd7,
        REQ_REVERSE   = 4'd8
    } t_req_code;

    // What every cell does in a cycle
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_LOAD   = 3'd1,
        CELL_UP     = 3'd2,
        CELL_DOWN   = 3'd3,
        CELL_MIRROR = 3'd4
    } t_cell_op;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [5:0]  position;
        logic [31:0] data_word;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_data;
        logic [6:0]  entry_count;
        logic        is_empty;
    } t_rsp;

endpackage

[src/bole_cell.sv]
module bole_cell
    import bole_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 7,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [CW-1:0]         i_target,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_prev,
    input  logic [DATA_WIDTH-1:0] i_next,
    input  logic [DATA_WIDTH-1:0] i_far,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_op)
            CELL_LOAD: begin
                if (MY_IDX == i_target) n_data = i_word;
            end
            CELL_UP: begin
                // entries at and after the target move one place up
                if (MY_IDX > i_target) n_data = i_prev;
                else if (MY_IDX == i_target) n_data = i_word;
            end
            CELL_DOWN: begin
                if (MY_IDX >= i_target) n_data = i_next;
            end
            CELL_MIRROR: n_data = i_far;
            default:     n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[src/bole_chain.sv]
module bole_chain
    import bole_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 7
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [CW-1:0]         i_target,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [CW-1:0]         i_rd_sel,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_prev [CAPACITY];
    logic [DATA_WIDTH-1:0] w_next [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = '0;
        end else begin : g_mid
            assign w_prev[g] = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next[g] = w_data[g];
        end else begin : g_inner
            assign w_next[g] = w_data[g+1];
        end

        bole_cell #(
            .DATA_WIDTH(DATA_WIDTH),
            .CW        (CW),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (i_op),
            .i_target(i_target),
            .i_word  (i_word),
            .i_prev  (w_prev[g]),
            .i_next  (w_next[g]),
            .i_far   (w_data[CAPACITY-1-g]),
            .o_data  (w_data[g])
        );
    end

    // one-hot select and OR across the cells
    always_comb begin
        o_rd_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CW'(k) == i_rd_sel) o_rd_data = o_rd_data | w_data[k];
        end
    end

endmodule

[src/bounded_ordered_list_engine.sv]
// Ordered list of up to CAPACITY words held in a chain of cells, one entry per
// cell; insert and remove move every later entry one cell in the same cycle.
// A request is registered when taken and executed in the cycle after, and no new
// request is accepted until it has executed. Reverse mirrors the whole chain in
// its execute cycle and then shifts it down one cell per cycle until the entries
// sit at the bottom again, when there are n entries with 2 <= n < CAPACITY. The
// result is held in an output register, and a new request is accepted while a
// previous result is taken in the same cycle.
module bounded_ordered_list_engine
    import bole_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_REV  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rev_left, n_rev_left;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_rsp, n_rsp;
    t_req          r_req;

    logic                  in_acc;
    t_cell_op              cell_op;
    logic [CW-1:0]         cell_target;
    logic [CW-1:0]         rd_sel;
    logic [DATA_WIDTH-1:0] chain_rd;
    logic [PW-1:0]         pos_ext, cnt_ext;
    logic                  pos_lt, pos_le, not_full, not_empty, ok;
    logic [31:0]           rd32;

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign pos_ext   = PW'(r_req.position);
    assign cnt_ext   = PW'(r_count);
    assign pos_lt    = pos_ext < cnt_ext;
    assign pos_le    = pos_ext <= cnt_ext;
    assign not_full  = r_count < CW'(CAPACITY);
    assign not_empty = r_count != '0;
    // an invalid read position returns the last entry
    assign rd_sel    = pos_lt ? CW'(r_req.position) : (r_count - CW'(1));

    bole_chain #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(DATA_WIDTH),
        .CW        (CW)
    ) u_chain (
        .i_clk    (i_clk),
        .i_op     (cell_op),
        .i_target (cell_target),
        .i_word   (DATA_WIDTH'(r_req.data_word)),
        .i_rd_sel (rd_sel),
        .o_rd_data(chain_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rev_left  = r_rev_left;
        n_out_valid = r_out_valid && i_out_stall;
        n_rsp       = r_rsp;
        cell_op     = CELL_HOLD;
        cell_target = '0;
        ok          = 1'b0;
        rd32        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (t_req_code'(r_req.req_type))
                    REQ_READ: begin
                        ok = pos_lt;
                        if (not_empty) rd32 = 32'(chain_rd);
                    end
                    REQ_ASSIGN: begin
                        if (pos_lt) begin
                            ok          = 1'b1;
                            cell_op     = CELL_LOAD;
                            cell_target = CW'(r_req.position);
                        end
                    end
                    REQ_INSERT: begin
                        if (pos_le && not_full) begin
                            ok          = 1'b1;
                            cell_op     = CELL_UP;
                            cell_target = CW'(r_req.position);
                            n_count     = r_count + CW'(1);
                        end
                    end
                    REQ_PUSH_TAIL: begin
                        if (not_full) begin
                            ok          = 1'b1;
                            cell_op     = CELL_UP;
                            cell_target = r_count;
                            n_count     = r_count + CW'(1);
                        end
                    end
                    REQ_PUSH_HEAD: begin
                        if (not_full) begin
                            ok      = 1'b1;
                            cell_op = CELL_UP;
                            n_count = r_count + CW'(1);
                        end
                    end
                    REQ_REMOVE: begin
                        if (pos_lt) begin
                            ok          = 1'b1;
                            cell_op     = CELL_DOWN;
                            cell_target = CW'(r_req.position);
                            n_count     = r_count - CW'(1);
                        end
                    end
                    REQ_POP_TAIL: begin
                        if (not_empty) begin
                            ok      = 1'b1;
                            n_count = r_count - CW'(1);
                        end
                    end
                    REQ_POP_HEAD: begin
                        if (not_empty) begin
                            ok      = 1'b1;
                            cell_op = CELL_DOWN;
                            n_count = r_count - CW'(1);
                        end
                    end
                    REQ_REVERSE: begin
                        ok = 1'b1;
                        if (r_count > CW'(1)) begin
                            // mirror the chain; entries then sit at the top end
                            cell_op = CELL_MIRROR;
                            if (not_full) begin
                                n_rev_left = CW'(CAPACITY) - r_count;
                                n_state    = S_REV;
                            end
                        end
                    end
                    default: ok = 1'b0;
                endcase
                n_out_valid       = 1'b1;
                n_rsp.ok          = ok;
                n_rsp.read_data   = rd32;
                n_rsp.entry_count = 7'(n_count);
                n_rsp.is_empty    = (n_count == '0);
            end
            S_REV: begin
                cell_op    = CELL_DOWN;
                n_rev_left = r_rev_left - CW'(1);
                if (r_rev_left == CW'(1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rev_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rev_left  <= n_rev_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (in_acc) r_req <= i_in_req;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    `AST_IMP(a_exec_out_free, r_state == S_EXEC, !r_out_valid, "result register busy in execute")
    `AST_IMP(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "entry count above capacity")
    `AST_NEXT(a_accept_exec, in_acc, r_state == S_EXEC, "accepted request not executed")
    `AST_NEXT(a_rev_count, r_state == S_REV, $stable(r_count), "count moved during reverse")

endmodule
